// ===== rtl/scsi_cdb_to_block_translator_top_defines.svh =====
// Assertion macros used by the checker file of the SCSI block command decoder.
`ifndef SCSI_CDB_TO_BLOCK_TRANSLATOR_TOP_DEFINES_SVH
`define SCSI_CDB_TO_BLOCK_TRANSLATOR_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds after a delay from the antecedent.
`define SCBT_ASSERT_TWO(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== rtl/scbt_pkg.sv =====
// Types and constants of the SCSI block command decoder.
`timescale 1ns / 1ps

package scbt_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCardTarget  = 2'd0,
    CfgCapacity    = 2'd1,
    CfgSectorBytes = 2'd2
  } cfg_idx_e;

  localparam logic [3:0]  CardTargetRst  = 4'd1;
  localparam logic [31:0] CapacityRst    = 32'd0;
  localparam logic [15:0] SectorBytesRst = 16'd512;

  // Opcodes the card serves.
  localparam logic [7:0] OpTestReady = 8'h00;
  localparam logic [7:0] OpRead6     = 8'h08;
  localparam logic [7:0] OpWrite6    = 8'h0a;
  localparam logic [7:0] OpInquiry   = 8'h12;
  localparam logic [7:0] OpStartStop = 8'h1b;
  localparam logic [7:0] OpReadCap   = 8'h25;
  localparam logic [7:0] OpRead10    = 8'h28;
  localparam logic [7:0] OpWrite10   = 8'h2a;
  localparam logic [7:0] OpSyncCache = 8'h35;

  // A 6-byte count of zero stands for this many blocks.
  localparam logic [15:0] ShortZeroCount = 16'h0100;

  typedef enum logic [2:0] {
    StTransfer    = 3'd0,
    StNoData      = 3'd1,
    StInquiry     = 3'd2,
    StCapacity    = 3'd3,
    StNoTarget    = 3'd4,
    StUnsupported = 3'd5,
    StRange       = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0]  command;
    logic        short_form;
    logic [63:0] descriptor_tail;
    logic [3:0]  target_id;
    logic [2:0]  unit_number;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic        is_write;
    logic [31:0] block_number;
    logic [15:0] block_count;
    logic [31:0] last_block_address;
    logic [15:0] block_size;
  } result_t;

  typedef struct packed {
    logic [3:0]  card_target;
    logic [31:0] capacity_blocks;
    logic [15:0] sector_bytes;
  } cfg_t;

endpackage

// ===== rtl/scbt_cfg_regs.sv =====
// Configuration registers of the SCSI block command decoder.
`timescale 1ns / 1ps

module scbt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scbt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scbt_pkg::CfgDataW-1:0] cfg_wdata_i,
  output scbt_pkg::cfg_t                cfg_o
);
  import scbt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCardTarget:  cfg_d.card_target     = cfg_wdata_i[3:0];
        CfgCapacity:    cfg_d.capacity_blocks = cfg_wdata_i[31:0];
        CfgSectorBytes: cfg_d.sector_bytes    = cfg_wdata_i[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.card_target     <= CardTargetRst;
      cfg_q.capacity_blocks <= CapacityRst;
      cfg_q.sector_bytes    <= SectorBytesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/scbt_decode.sv =====
// Combinational classification of one registered command descriptor.
`timescale 1ns / 1ps

module scbt_decode #(
  parameter int unsigned MAX_TARGETS = 16
) (
  input  scbt_pkg::cmd_t    cmd_i,
  input  scbt_pkg::cfg_t    cfg_i,
  output scbt_pkg::result_t result_o
);
  import scbt_pkg::*;

  logic        target_ok;
  logic [31:0] blk;
  logic [15:0] cnt;
  logic [7:0]  short_cnt;
  logic [32:0] blk_end;
  logic        out_of_range;
  logic        is_write;

  assign target_ok = (cfg_i.card_target != 4'd0) &&
                     ({1'b0, cfg_i.card_target} < 5'(MAX_TARGETS)) &&
                     (cmd_i.target_id == cfg_i.card_target) &&
                     (cmd_i.unit_number == 3'd0);

  assign short_cnt = cmd_i.descriptor_tail[39:32];

  always_comb begin
    if (cmd_i.short_form) begin
      // The top three bits of byte 1 hold the old LUN field and are dropped.
      blk = {11'd0, cmd_i.descriptor_tail[60:40]};
      cnt = (short_cnt == 8'd0) ? ShortZeroCount : {8'd0, short_cnt};
    end else begin
      blk = cmd_i.descriptor_tail[55:24];
      cnt = cmd_i.descriptor_tail[15:0];
    end
  end

  // The end of the transfer is formed one bit wider so it cannot wrap.
  assign blk_end      = {1'b0, blk} + {17'd0, cnt};
  assign out_of_range = (blk >= cfg_i.capacity_blocks) ||
                        (blk_end > {1'b0, cfg_i.capacity_blocks});
  assign is_write     = (cmd_i.command == OpWrite6) || (cmd_i.command == OpWrite10);

  always_comb begin
    result_o = '0;
    if (!target_ok) begin
      result_o.status = StNoTarget;
    end else begin
      unique case (cmd_i.command)
        OpRead6, OpWrite6, OpRead10, OpWrite10: begin
          result_o.status       = out_of_range ? StRange : StTransfer;
          result_o.is_write     = is_write;
          result_o.block_number = blk;
          result_o.block_count  = cnt;
        end
        OpInquiry: result_o.status = StInquiry;
        OpTestReady, OpStartStop, OpSyncCache: result_o.status = StNoData;
        OpReadCap: begin
          result_o.status             = StCapacity;
          result_o.last_block_address = cfg_i.capacity_blocks - 32'd1;
          result_o.block_size         = cfg_i.sector_bytes;
        end
        default: result_o.status = StUnsupported;
      endcase
    end
  end

endmodule

// ===== rtl/scsi_cdb_to_block_translator_top.sv =====
// Top level of the SCSI block command decoder for a single memory card.
`timescale 1ns / 1ps

// Usage
// A command item is offered on cmd_i with start_i high and is taken at a
// rising clock edge where busy_o is low. Each item holds the opcode, the
// descriptor form, descriptor bytes 1 to 8, the target and the logical unit.
// Exactly one result item follows for every command. It is shown on result_o
// for one cycle with done_o high; the receiver cannot stall it, so it must
// take the result in that cycle.
// The command is captured in an input register; the decode and the 33-bit
// range check then run on it and land in the result register. A new command
// may be taken in every cycle while busy_o is low, so the throughput is one
// item per cycle; the rate is set by the single decode stage between the two
// registers.
// The three configuration registers (card target, capacity in blocks and
// block size) are written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// take effect at once; they should only change while no command is in
// flight. A write to an index past the last register is dropped.
// Reset clears both stage valid flags, loads the register defaults and holds
// busy_o high until the first clock edge after reset is released.

module scsi_cdb_to_block_translator_top #(
  parameter int unsigned MAX_TARGETS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  scbt_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output scbt_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [scbt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scbt_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import scbt_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd_q;
  logic    cmd_vld_q, cmd_vld_d;
  result_t res_d, res_q;
  logic    done_q;
  logic    busy_q;

  scbt_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // The block is only busy in the cycle that follows reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign cmd_vld_d = start_i && !busy_q;

  // Input stage: the valid flag is control, the command itself is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_vld_d) begin
      cmd_q <= cmd_i;
    end
  end

  scbt_decode #(
    .MAX_TARGETS(MAX_TARGETS)
  ) u_decode (
    .cmd_i   (cmd_q),
    .cfg_i   (cfg),
    .result_o(res_d)
  );

  // Result stage: one result per captured command, shown for a single cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_vld_q) begin
      res_q <= res_d;
    end
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== rtl/scbt_checker.sv =====
// Port-level assertions of the SCSI block command decoder and their binding.
`timescale 1ns / 1ps
`include "scsi_cdb_to_block_translator_top_defines.svh"

module scbt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input logic              done_i,
  input scbt_pkg::result_t result_i
);
  import scbt_pkg::*;

  `SCBT_ASSERT_TWO(a_result_follows, start_i && !busy_i, done_i, "result missing after command")
  `SCBT_ASSERT_NOW(a_no_spurious, done_i, $past(start_i && !busy_i, 2), "result without command")
  `SCBT_ASSERT_NOW(a_cap_clean, done_i && (result_i.status == StCapacity), (result_i.block_number == 32'd0) && (result_i.block_count == 16'd0) && !result_i.is_write, "capacity result carries transfer fields")
  `SCBT_ASSERT_NOW(a_other_clean, done_i && (result_i.status != StCapacity), (result_i.last_block_address == 32'd0) && (result_i.block_size == 16'd0), "capacity fields set outside capacity result")

endmodule

bind scsi_cdb_to_block_translator_top scbt_checker u_scbt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .done_i  (done_o),
  .result_i(result_o)
);
